// File: hw/rtl/acauto_pkg.sv
// Shared types and constants for the Aho-Corasick automaton core.
// Holds beat structs, opcode and status codes, and the sequencer state type.
// No dependencies.
package acauto_pkg;

    localparam int ALPHABET_SIZE_DEF = 26;
    localparam int MAX_NODES_DEF     = 1024;

    localparam int OPCODE_W = 3;
    localparam int SYMBOL_W = 5;
    localparam int NODE_W   = 10;
    localparam int COUNT_W  = 16;
    localparam int STATUS_W = 2;

    localparam logic [OPCODE_W-1:0] OP_INSERT     = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_END        = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_TRANSITION = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_SUFFIX     = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_COUNT      = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_UNUSED = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_LATE   = 2'd3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [SYMBOL_W-1:0] symbol;
        logic [NODE_W-1:0]   node;
    } in_beat_t;

    typedef struct packed {
        logic [NODE_W-1:0]   result_node;
        logic [COUNT_W-1:0]  match_count;
        logic [STATUS_W-1:0] status;
    } out_beat_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CHK,
        S_INS_NODE,
        S_END_RD,
        S_END_WR,
        S_BLD_INIT,
        S_BLD_POP,
        S_BLD_V,
        S_BLD_VL,
        S_BLD_E1,
        S_BLD_E2,
        S_BLD_E3,
        S_BLD_E4,
        S_BLD_E5,
        S_Q_ADDR,
        S_Q_RD,
        S_Q_DATA,
        S_RESP
    } state_t;

endpackage

// File: hw/rtl/acauto_ram.sv
// Simple dual-port synchronous RAM: one write port, one read port.
// Read data is registered; no dependencies.
module acauto_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 10
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hw/rtl/aho_corasick_automaton_core.sv
// Top level of the Aho-Corasick automaton: trie build, eager table build, queries.
// Depends on acauto_pkg and acauto_ram.
//
//  channel | signals                      | beat type
//  in      | in_valid, in_ready, in_beat  | in_beat_t  (opcode, symbol, node)
//  out     | out_valid, out_ready, out_beat | out_beat_t (result_node, match_count, status)
//
// Inserts, end-pattern beats and queries are paced by the serial reads of the edge and
// node RAMs (one read port each, registered read data). A beat that changes nothing
// (insert or end after queries, insert with a symbol outside the alphabet, unknown
// opcode) skips the RAMs and goes straight to the response; an unused node index or a
// transition on a symbol outside the alphabet is answered after the address check alone.
// The first query runs the table build: it visits each node and then each of its symbols,
// walked in breadth-first order through a queue RAM.
// No clearing pass after reset: child entries are checked against the node's
// parent and symbol. A stalled output holds in the output register while the
// next beat is accepted; the result after that waits until the register frees.
module aho_corasick_automaton_core #(
    parameter int ALPHABET_SIZE = acauto_pkg::ALPHABET_SIZE_DEF,
    parameter int MAX_NODES     = acauto_pkg::MAX_NODES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  acauto_pkg::in_beat_t  in_beat,
    output logic                  out_valid,
    input  logic                  out_ready,
    output acauto_pkg::out_beat_t out_beat
);

    import acauto_pkg::*;

    localparam int NW     = $clog2(MAX_NODES);
    localparam int NU_W   = $clog2(MAX_NODES + 1);
    localparam int SW     = (ALPHABET_SIZE > 2) ? $clog2(ALPHABET_SIZE) : 1;
    localparam int EDEPTH = MAX_NODES * ALPHABET_SIZE;
    localparam int EW     = $clog2(EDEPTH);
    localparam int CMP_W  = (NU_W > NODE_W) ? NU_W : NODE_W;
    localparam int AS_W   = 9;

    typedef struct packed {
        logic [NW-1:0]      parent;
        logic [SW-1:0]      esym;
        logic [COUNT_W-1:0] endcnt;
        logic [NW-1:0]      link;
        logic [COUNT_W-1:0] mcount;
    } node_word_t;

    localparam int NODE_WORD_W = $bits(node_word_t);

    state_t              state_reg, state_next;
    in_beat_t            item_reg, item_next;
    logic [NU_W-1:0]     nu_reg, nu_next;
    logic [NW-1:0]       cur_reg, cur_next;
    logic                qs_reg, qs_next;
    out_beat_t           res_reg, res_next;
    out_beat_t           out_reg, out_next;
    logic                out_valid_reg, out_valid_next;
    logic [EW-1:0]       idx_reg, idx_next;
    logic [NW-1:0]       v_reg, v_next;
    logic [EW-1:0]       vbase_reg, vbase_next;
    logic [EW-1:0]       lbase_reg, lbase_next;
    logic [SW-1:0]       c_reg, c_next;
    logic [NW-1:0]       u_reg, u_next;
    logic [NW-1:0]       fb_reg, fb_next;
    node_word_t          unode_reg, unode_next;
    logic [NU_W-1:0]     head_reg, head_next;
    logic [NU_W-1:0]     tail_reg, tail_next;

    logic                edge_we, edge_re;
    logic [EW-1:0]       edge_wa, edge_ra;
    logic [NW-1:0]       edge_wd, edge_rd;
    logic                node_we, node_re;
    logic [NW-1:0]       node_wa, node_ra;
    node_word_t          node_wd, node_rd;
    logic [NODE_WORD_W-1:0] node_rd_raw;
    logic                q_we, q_re;
    logic [NW-1:0]       q_wa, q_ra;
    logic [NW-1:0]       q_wd, q_rd;

    logic                sym_ok;
    logic                node_ok;
    logic                child_ok;
    logic                last_c;
    logic [COUNT_W:0]    sum;

    acauto_ram #(.DEPTH(EDEPTH), .WIDTH(NW)) u_edge_ram (
        .clk     (clk),
        .wr_en   (edge_we),
        .wr_addr (edge_wa),
        .wr_data (edge_wd),
        .rd_en   (edge_re),
        .rd_addr (edge_ra),
        .rd_data (edge_rd)
    );

    acauto_ram #(.DEPTH(MAX_NODES), .WIDTH(NODE_WORD_W)) u_node_ram (
        .clk     (clk),
        .wr_en   (node_we),
        .wr_addr (node_wa),
        .wr_data (node_wd),
        .rd_en   (node_re),
        .rd_addr (node_ra),
        .rd_data (node_rd_raw)
    );

    acauto_ram #(.DEPTH(MAX_NODES), .WIDTH(NW)) u_queue_ram (
        .clk     (clk),
        .wr_en   (q_we),
        .wr_addr (q_wa),
        .wr_data (q_wd),
        .rd_en   (q_re),
        .rd_addr (q_ra),
        .rd_data (q_rd)
    );

    assign node_rd = node_word_t'(node_rd_raw);

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_beat  = out_reg;

    assign sym_ok  = AS_W'(item_reg.symbol) < AS_W'(ALPHABET_SIZE);
    assign node_ok = CMP_W'(item_reg.node) < CMP_W'(nu_reg);
    assign last_c  = (c_reg == SW'(ALPHABET_SIZE - 1));
    assign sum     = {1'b0, unode_reg.endcnt} + {1'b0, node_rd.mcount};

    // A stored child is real only if it names this parent and symbol.
    always_comb
    begin
        child_ok = 1'b0;
        case (state_reg)
            S_INS_NODE:
            begin
                child_ok = (u_reg != '0) && (NU_W'(u_reg) < nu_reg)
                    && (node_rd.parent == cur_reg)
                    && (node_rd.esym == SW'(item_reg.symbol));
            end
            S_BLD_E4:
            begin
                child_ok = (u_reg != '0) && (NU_W'(u_reg) < nu_reg)
                    && (node_rd.parent == v_reg) && (node_rd.esym == c_reg)
                    && (tail_reg < NU_W'(MAX_NODES));
            end
            default:
            begin
                child_ok = 1'b0;
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_beat.opcode)
                        OP_INSERT:
                        begin
                            if (qs_reg || (AS_W'(in_beat.symbol) >= AS_W'(ALPHABET_SIZE)))
                            begin
                                state_next = S_RESP;
                            end
                            else
                            begin
                                state_next = S_INS_RD;
                            end
                        end
                        OP_END:
                        begin
                            state_next = qs_reg ? S_RESP : S_END_RD;
                        end
                        OP_TRANSITION, OP_SUFFIX, OP_COUNT:
                        begin
                            state_next = qs_reg ? S_Q_ADDR : S_BLD_INIT;
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_INS_RD:   state_next = S_INS_CHK;
            S_INS_CHK:  state_next = S_INS_NODE;
            S_INS_NODE: state_next = S_RESP;
            S_END_RD:   state_next = S_END_WR;
            S_END_WR:   state_next = S_RESP;
            S_BLD_INIT: state_next = S_BLD_POP;
            S_BLD_POP:  state_next = (head_reg == tail_reg) ? S_Q_ADDR : S_BLD_V;
            S_BLD_V:    state_next = S_BLD_VL;
            S_BLD_VL:   state_next = S_BLD_E1;
            S_BLD_E1:   state_next = S_BLD_E2;
            S_BLD_E2:   state_next = S_BLD_E3;
            S_BLD_E3:   state_next = S_BLD_E4;
            S_BLD_E4:
            begin
                if (child_ok)
                begin
                    state_next = S_BLD_E5;
                end
                else
                begin
                    state_next = last_c ? S_BLD_POP : S_BLD_E1;
                end
            end
            S_BLD_E5:   state_next = last_c ? S_BLD_POP : S_BLD_E1;
            S_Q_ADDR:
            begin
                if (!node_ok || ((item_reg.opcode == OP_TRANSITION) && !sym_ok))
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_Q_RD;
                end
            end
            S_Q_RD:     state_next = S_Q_DATA;
            S_Q_DATA:   state_next = S_RESP;
            S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb
    begin
        item_next      = item_reg;
        nu_next        = nu_reg;
        cur_next       = cur_reg;
        qs_next        = qs_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        idx_next       = idx_reg;
        v_next         = v_reg;
        vbase_next     = vbase_reg;
        lbase_next     = lbase_reg;
        c_next         = c_reg;
        u_next         = u_reg;
        fb_next        = fb_reg;
        unode_next     = unode_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;

        edge_we = 1'b0;
        edge_wa = idx_reg;
        edge_wd = '0;
        edge_re = 1'b0;
        edge_ra = idx_reg;
        node_we = 1'b0;
        node_wa = '0;
        node_wd = '0;
        node_re = 1'b0;
        node_ra = '0;
        q_we    = 1'b0;
        q_wa    = tail_reg[NW-1:0];
        q_wd    = '0;
        q_re    = 1'b0;
        q_ra    = head_reg[NW-1:0];

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next = in_beat;
                    idx_next  = EW'(EW'(cur_reg) * EW'(ALPHABET_SIZE)) + EW'(in_beat.symbol);
                    res_next  = '0;
                    case (in_beat.opcode)
                        OP_INSERT, OP_END:
                        begin
                            res_next.result_node = NODE_W'(cur_reg);
                            res_next.status      = qs_reg ? STAT_LATE : STAT_OK;
                        end
                        default:
                        begin
                            res_next = '0;
                        end
                    endcase
                end
            end
            S_INS_RD:
            begin
                edge_re = 1'b1;
                edge_ra = idx_reg;
            end
            S_INS_CHK:
            begin
                u_next  = edge_rd;
                node_re = 1'b1;
                node_ra = edge_rd;
            end
            S_INS_NODE:
            begin
                if (child_ok)
                begin
                    cur_next             = u_reg;
                    res_next.result_node = NODE_W'(u_reg);
                end
                else if (nu_reg == NU_W'(MAX_NODES))
                begin
                    res_next.status = STAT_FULL;
                end
                else
                begin
                    edge_we        = 1'b1;
                    edge_wa        = idx_reg;
                    edge_wd        = NW'(nu_reg);
                    node_we        = 1'b1;
                    node_wa        = NW'(nu_reg);
                    node_wd.parent = cur_reg;
                    node_wd.esym   = SW'(item_reg.symbol);
                    cur_next       = NW'(nu_reg);
                    nu_next        = nu_reg + NU_W'(1);
                    res_next.result_node = NODE_W'(nu_reg);
                end
            end
            S_END_RD:
            begin
                node_re = 1'b1;
                node_ra = cur_reg;
            end
            S_END_WR:
            begin
                node_we = 1'b1;
                node_wa = cur_reg;
                node_wd = node_rd;
                if (node_rd.endcnt != COUNT_MAX)
                begin
                    node_wd.endcnt = node_rd.endcnt + COUNT_W'(1);
                end
                cur_next = '0;
            end
            S_BLD_INIT:
            begin
                qs_next   = 1'b1;
                node_we   = 1'b1;
                node_wa   = '0;
                q_we      = 1'b1;
                q_wa      = '0;
                head_next = '0;
                tail_next = NU_W'(1);
            end
            S_BLD_POP:
            begin
                q_re = (head_reg != tail_reg);
            end
            S_BLD_V:
            begin
                v_next  = q_rd;
                node_re = 1'b1;
                node_ra = q_rd;
            end
            S_BLD_VL:
            begin
                vbase_next = EW'(EW'(v_reg) * EW'(ALPHABET_SIZE));
                lbase_next = EW'(EW'(node_rd.link) * EW'(ALPHABET_SIZE));
                c_next     = '0;
            end
            S_BLD_E1:
            begin
                idx_next = vbase_reg + EW'(c_reg);
                edge_re  = 1'b1;
                edge_ra  = vbase_reg + EW'(c_reg);
            end
            S_BLD_E2:
            begin
                u_next  = edge_rd;
                edge_re = 1'b1;
                edge_ra = lbase_reg + EW'(c_reg);
            end
            S_BLD_E3:
            begin
                fb_next = (v_reg == '0) ? '0 : edge_rd;
                node_re = 1'b1;
                node_ra = u_reg;
            end
            S_BLD_E4:
            begin
                if (child_ok)
                begin
                    unode_next = node_rd;
                    node_re    = 1'b1;
                    node_ra    = fb_reg;
                end
                else
                begin
                    // no child here: the transition falls back
                    edge_we = 1'b1;
                    edge_wa = idx_reg;
                    edge_wd = fb_reg;
                    if (last_c)
                    begin
                        head_next = head_reg + NU_W'(1);
                    end
                    else
                    begin
                        c_next = c_reg + SW'(1);
                    end
                end
            end
            S_BLD_E5:
            begin
                edge_we        = 1'b1;
                edge_wa        = idx_reg;
                edge_wd        = u_reg;
                node_we        = 1'b1;
                node_wa        = u_reg;
                node_wd        = unode_reg;
                node_wd.link   = fb_reg;
                node_wd.mcount = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
                q_we           = 1'b1;
                q_wa           = tail_reg[NW-1:0];
                q_wd           = u_reg;
                tail_next      = tail_reg + NU_W'(1);
                if (last_c)
                begin
                    head_next = head_reg + NU_W'(1);
                end
                else
                begin
                    c_next = c_reg + SW'(1);
                end
            end
            S_Q_ADDR:
            begin
                res_next = '0;
                idx_next = EW'(EW'(NW'(item_reg.node)) * EW'(ALPHABET_SIZE))
                    + EW'(item_reg.symbol);
                if (!node_ok)
                begin
                    res_next.status = STAT_UNUSED;
                end
                else if (item_reg.opcode == OP_TRANSITION && !sym_ok)
                begin
                    res_next.result_node = item_reg.node;
                end
            end
            S_Q_RD:
            begin
                if (item_reg.opcode == OP_TRANSITION)
                begin
                    edge_re = 1'b1;
                    edge_ra = idx_reg;
                end
                else
                begin
                    node_re = 1'b1;
                    node_ra = NW'(item_reg.node);
                end
            end
            S_Q_DATA:
            begin
                case (item_reg.opcode)
                    OP_TRANSITION:
                    begin
                        res_next.result_node = NODE_W'(edge_rd);
                    end
                    OP_SUFFIX:
                    begin
                        res_next.result_node = NODE_W'(node_rd.link);
                    end
                    default:
                    begin
                        res_next.result_node = item_reg.node;
                        res_next.match_count = node_rd.mcount;
                    end
                endcase
            end
            S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            nu_reg        <= NU_W'(1);
            cur_reg       <= '0;
            qs_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            nu_reg        <= nu_next;
            cur_reg       <= cur_next;
            qs_reg        <= qs_next;
            out_valid_reg <= out_valid_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
        idx_reg   <= idx_next;
        v_reg     <= v_next;
        vbase_reg <= vbase_next;
        lbase_reg <= lbase_next;
        c_reg     <= c_next;
        u_reg     <= u_next;
        fb_reg    <= fb_next;
        unode_reg <= unode_next;
    end

endmodule

// File: dv/aho_corasick_automaton_checker.sv
// Checker for aho_corasick_automaton_core: watches both channels, predicts each result
// beat from a behavioral trie and automaton, and compares it field by field.
// Depends on acauto_pkg.
module aho_corasick_automaton_checker #(
    parameter int ALPHABET_SIZE = acauto_pkg::ALPHABET_SIZE_DEF,
    parameter int MAX_NODES     = acauto_pkg::MAX_NODES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  acauto_pkg::in_beat_t  in_beat,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  acauto_pkg::out_beat_t out_beat,
    output int                    fail_count,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import acauto_pkg::*;

    // Trie and closed automaton; a zero child means absent since the root is never a child
    int        kid       [MAX_NODES][ALPHABET_SIZE];
    int        goto_next [MAX_NODES][ALPHABET_SIZE];
    int        fail_link [MAX_NODES];
    int        end_marks [MAX_NODES];
    int        hit_count [MAX_NODES];
    int        bfs_order [MAX_NODES];
    int        node_total;
    int        cursor;
    bit        closed;
    out_beat_t expected_beats[$];

    initial
    begin
        foreach (kid[i, j]) kid[i][j] = 0;
        foreach (end_marks[i]) end_marks[i] = 0;
        node_total = 1;
        cursor     = 0;
        closed     = 0;
        fail_count = 0;
        pending    = 0;
    end

    // Breadth-first build of suffix links, full transitions and match counts
    function automatic void close_trie();
        int head;
        int tail;
        int v;
        int u;
        int fb;
        int sum;
        head = 0;
        tail = 0;
        fail_link[0] = 0;
        hit_count[0] = 0;
        bfs_order[tail++] = 0;
        while (head < tail)
        begin
            v = bfs_order[head++];
            for (int c = 0; c < ALPHABET_SIZE; c++)
            begin
                u  = kid[v][c];
                fb = (v == 0) ? 0 : goto_next[fail_link[v]][c];
                if (u != 0 && tail < MAX_NODES)
                begin
                    goto_next[v][c] = u;
                    fail_link[u]    = fb;
                    sum             = end_marks[u] + hit_count[fb];
                    hit_count[u]    = (sum > int'(COUNT_MAX)) ? int'(COUNT_MAX) : sum;
                    bfs_order[tail++] = u;
                end
                else
                begin
                    goto_next[v][c] = fb;
                end
            end
        end
    endfunction

    function automatic out_beat_t predict_beat(in_beat_t b);
        out_beat_t r;
        int        sym;
        int        nd;
        r   = '0;
        sym = int'(b.symbol);
        nd  = int'(b.node);
        case (b.opcode)
            OP_INSERT, OP_END:
            begin
                if (closed)
                    r.status = STAT_LATE;
                else if (b.opcode == OP_INSERT)
                begin
                    if (sym < ALPHABET_SIZE)
                    begin
                        if (kid[cursor][sym] != 0)
                            cursor = kid[cursor][sym];
                        else if (node_total >= MAX_NODES)
                            r.status = STAT_FULL;
                        else
                        begin
                            kid[cursor][sym] = node_total;
                            cursor = node_total;
                            node_total++;
                        end
                    end
                end
                r.result_node = cursor[NODE_W-1:0];
                if (!closed && b.opcode == OP_END)
                begin
                    if (end_marks[cursor] < int'(COUNT_MAX))
                        end_marks[cursor]++;
                    cursor = 0;
                end
            end
            OP_TRANSITION, OP_SUFFIX, OP_COUNT:
            begin
                if (!closed)
                begin
                    closed = 1;
                    close_trie();
                end
                if (nd >= node_total)
                    r.status = STAT_UNUSED;
                else if (b.opcode == OP_TRANSITION)
                    r.result_node = (sym < ALPHABET_SIZE) ?
                        goto_next[nd][sym][NODE_W-1:0] : b.node;
                else if (b.opcode == OP_SUFFIX)
                    r.result_node = fail_link[nd][NODE_W-1:0];
                else
                begin
                    r.result_node = b.node;
                    r.match_count = hit_count[nd][COUNT_W-1:0];
                end
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    task automatic report(string what, int want, int got);
        $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
        fail_count++;
    endtask

    always @(posedge clk)
    begin
        out_beat_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                expected_beats = {expected_beats, predict_beat(in_beat)};
            if (out_valid && out_ready)
            begin
                if (expected_beats.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected", $realtime);
                    fail_count++;
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (out_beat.result_node !== want.result_node)
                        report("result_node", want.result_node, out_beat.result_node);
                    if (out_beat.match_count !== want.match_count)
                        report("match_count", want.match_count, out_beat.match_count);
                    if (out_beat.status !== want.status)
                        report("status", want.status, out_beat.status);
                end
            end
            pending <= expected_beats.size();
        end
    end

endmodule

// File: dv/tb.sv
// Testbench top for aho_corasick_automaton_core: drives trie inserts that fill the node
// store, then automaton queries, with bursty input and a stalling receiver.
// Depends on acauto_pkg, aho_corasick_automaton_core and aho_corasick_automaton_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import acauto_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_beat_t  in_beat;
    logic      out_valid;
    logic      out_ready;
    out_beat_t out_beat;
    int        fail_count;
    int        pending;
    int        cycles;
    int        burst_left;
    int        stall_mode;
    int        stall_left;

    aho_corasick_automaton_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_beat   (in_beat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_beat  (out_beat)
    );

    aho_corasick_automaton_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_beat    (in_beat),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_beat   (out_beat),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver: switch between always ready, random stalls and long stalls
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(10, 200);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= $urandom_range(0, 1);
            default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Hold the beat until accepted; between bursts drop valid for a random gap
    task automatic send(logic [OPCODE_W-1:0] op, int sym, int nd);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 12);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 30);
        end
        in_valid <= 1'b1;
        in_beat  <= '{opcode: op, symbol: sym[SYMBOL_W-1:0], node: nd[NODE_W-1:0]};
        do @(posedge clk); while (!in_ready);
        burst_left--;
    endtask

    function automatic int pick_symbol();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(26, 31) : $urandom_range(0, 25);
    endfunction

    initial
    begin
        int len;
        int pick;
        cycles     = 0;
        burst_left = 0;
        stall_mode = 0;
        stall_left = 0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_beat    = '0;
        out_ready  = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed insert phase: empty pattern, repeated prefix, symbol extremes, unknown opcodes
        send(OP_END, 0, 0);
        send(OP_END, 0, 0);
        send(OP_INSERT, 0, 0);
        send(OP_INSERT, 25, 0);
        send(OP_END, 0, 0);
        send(OP_INSERT, 0, 0);
        send(OP_INSERT, 25, 0);
        send(OP_END, 0, 0);
        send(OP_INSERT, 25, 0);
        send(OP_INSERT, 31, 1023);
        send(OP_INSERT, 26, 0);
        send(OP_END, 0, 0);
        send(3'd5, 31, 1023);
        send(3'd7, 0, 0);

        // Random patterns; a narrow alphabet now and then builds shared prefixes
        for (int i = 0; i < 380; i++)
        begin
            len = $urandom_range(1, 12);
            pick = $urandom_range(0, 2);
            for (int k = 0; k < len; k++)
                send(OP_INSERT, (pick == 0) ? $urandom_range(0, 2) : pick_symbol(),
                     $urandom_range(0, 1023));
            send(OP_END, 0, $urandom_range(0, 1023));
            i += len;
        end

        // One long chain to exhaust the node store, then inserts that overflow
        for (int i = 0; i < 760; i++)
            send(OP_INSERT, $urandom_range(0, 25), 0);
        send(OP_INSERT, 0, 0);
        send(OP_END, 0, 0);
        send(OP_INSERT, 25, 0);
        send(OP_INSERT, 7, 0);

        // Query phase: the first query closes the trie
        send(OP_TRANSITION, 0, 0);
        send(OP_TRANSITION, 25, 1023);
        send(OP_TRANSITION, 31, 1023);
        send(OP_SUFFIX, 0, 0);
        send(OP_SUFFIX, 0, 1023);
        send(OP_COUNT, 0, 0);
        send(OP_COUNT, 0, 1);
        send(OP_INSERT, 3, 0);
        send(OP_END, 0, 0);
        send(3'd6, 31, 1023);

        for (int i = 0; i < 200; i++)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 8)
                send(OP_TRANSITION, pick_symbol(), $urandom_range(0, 1023));
            else if (pick < 13)
                send(OP_SUFFIX, $urandom_range(0, 31), $urandom_range(0, 1023));
            else if (pick < 18)
                send(OP_COUNT, $urandom_range(0, 31), $urandom_range(0, 1023));
            else
                send($urandom_range(0, 1) ? OP_INSERT : 3'($urandom_range(5, 7)),
                     $urandom_range(0, 31), $urandom_range(0, 1023));
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/acauto_pkg.sv
hw/rtl/acauto_ram.sv
hw/rtl/aho_corasick_automaton_core.sv
dv/aho_corasick_automaton_checker.sv
dv/tb.sv
